### hdl/pidtw_pkg.sv
// Shared constants and types for the PID controller with twiddle gain tuning.
package pidtw_pkg;

   // Default gain storage width, Q16.16.
   localparam int GAIN_WIDTH_DEF = 32;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Stream payload widths.
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 160;

   // Step sizes are unsigned Q16.16 and never exceed the int32 maximum.
   localparam int STEP_W = 31;
   localparam logic [STEP_W-1:0] STEP_ONE  = 31'd65536;
   localparam logic [STEP_W-1:0] STEP_MAX  = 31'h7FFF_FFFF;
   localparam logic [STEP_W-1:0] TOL_RESET = 31'd66;

   // Step scale factors in Q16.16: 1.1 to grow and 0.9 to shrink.
   localparam int SCALE_W = 17;
   localparam logic [SCALE_W-1:0] GROW_K   = 17'd72090;
   localparam logic [SCALE_W-1:0] SHRINK_K = 17'd58982;

   // Reset value of the best score: the largest positive int32.
   localparam logic signed [31:0] BEST_RESET = 32'sh7FFF_FFFF;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_GAIN_P   = 3'd0,
      REG_GAIN_I   = 3'd1,
      REG_GAIN_D   = 3'd2,
      REG_TUNE_EN  = 3'd3,
      REG_STEP_TOL = 3'd4
   } reg_index_type;

   // Gain currently being tuned.
   typedef enum logic [1:0] {
      CO_P = 2'd0,
      CO_D = 2'd1,
      CO_I = 2'd2
   } coord_type;

   // Twiddle phase for the current gain.
   typedef enum logic [1:0] {
      PH_TRY_UP   = 2'd0,
      PH_TRY_DOWN = 2'd1,
      PH_SETTLE   = 2'd2,
      PH_NEXT     = 2'd3
   } phase_type;

endpackage

### hdl/pid_controller_with_twiddle_tuning.sv
// PID controller with on-line twiddle tuning of its three gains.
// The result beat is registered at the edge that takes the sample beat and is
// offered on rsp_ from the next cycle.
// Throughput: one sample per cycle; a sample waits only while the result register holds
// a beat that rsp_tready has not yet taken.
// Reset is synchronous and restores all gains, steps, scores and the result valid.
module pid_controller_with_twiddle_tuning #(
   parameter int GAIN_WIDTH = pidtw_pkg::GAIN_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Sample channel. req_tdata: error_sample [15:0].
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pidtw_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Result channel. rsp_tdata: drive [31:0], gain_p_now [63:32],
   // gain_i_now [95:64], gain_d_now [127:96], best_score [159:128].
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [pidtw_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: tuning_active [0].
   output logic                                 rsp_tuser,
   // Configuration port.
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pidtw_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pidtw_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pidtw_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);

   // Gains saturate to at most 32 bits, since the result fields are 32 bits wide.
   localparam int GainEff = (GAIN_WIDTH > 32) ? 32 : GAIN_WIDTH;
   localparam int AccW    = GainEff + 34;
   localparam int StepW   = pidtw_pkg::STEP_W;

   localparam logic signed [34:0] GainMax = {{(36 - GainEff){1'b0}}, {(GainEff - 1){1'b1}}};
   localparam logic signed [34:0] GainMin = {{(36 - GainEff){1'b1}}, {(GainEff - 1){1'b0}}};
   localparam logic signed [AccW-1:0] DriveMax = {{(AccW - 32){1'b0}}, 32'h7FFF_FFFF};
   localparam logic signed [AccW-1:0] DriveMin = {{(AccW - 32){1'b1}}, 32'h8000_0000};

   // Saturate a widened gain value to the gain range.
   function automatic logic signed [GainEff-1:0] sat_gain(input logic signed [34:0] v);
      logic signed [GainEff-1:0] r;
      if (v > GainMax) begin
         r = GainMax[GainEff-1:0];
      end else if (v < GainMin) begin
         r = GainMin[GainEff-1:0];
      end else begin
         r = v[GainEff-1:0];
      end
      return r;
   endfunction

   // Magnitude of a score; the most negative value maps to 2^31 without wrap.
   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? (~v + 32'd1) : v;
      return r;
   endfunction

   // ---------------------------------------------------------------- registers
   logic [31:0]                 gain_p_init_ff, gain_i_init_ff, gain_d_init_ff;
   logic                        tune_en_ff;
   logic [StepW-1:0]            step_tol_ff;

   logic signed [15:0]          last_ff, last_in;
   logic signed [16:0]          delta_ff, delta_in;
   logic signed [31:0]          sum_ff, sum_in;
   logic signed [GainEff-1:0]   gain_p_ff, gain_p_in;
   logic signed [GainEff-1:0]   gain_i_ff, gain_i_in;
   logic signed [GainEff-1:0]   gain_d_ff, gain_d_in;
   logic [StepW-1:0]            step_p_ff, step_p_in;
   logic [StepW-1:0]            step_i_ff, step_i_in;
   logic [StepW-1:0]            step_d_ff, step_d_in;
   logic signed [31:0]          trial_ff;
   logic signed [31:0]          best_ff, best_in;
   pidtw_pkg::coord_type        coord_ff, coord_in;
   pidtw_pkg::phase_type        phase_ff, phase_in;

   // Result register.
   logic                        rsp_valid_ff;
   logic [pidtw_pkg::RSP_DATA_W-1:0] out_data_ff;
   logic                        out_user_ff;

   // ---------------------------------------------------------------- handshakes
   logic take, cfg_wr;
   pidtw_pkg::reg_index_type    cfg_idx;

   // A new sample is taken whenever the result register is empty or being emptied.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   assign cfg_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_idx = pidtw_pkg::reg_index_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;

   // Register read-back.
   always_comb begin
      case (cfg_idx)
         pidtw_pkg::REG_GAIN_P:   csr_prdata = gain_p_init_ff;
         pidtw_pkg::REG_GAIN_I:   csr_prdata = gain_i_init_ff;
         pidtw_pkg::REG_GAIN_D:   csr_prdata = gain_d_init_ff;
         pidtw_pkg::REG_TUNE_EN:  csr_prdata = {31'd0, tune_en_ff};
         pidtw_pkg::REG_STEP_TOL: csr_prdata = {1'b0, step_tol_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- sample update
   logic signed [15:0]          e_c;
   logic signed [32:0]          sum_wide;
   logic [32:0]                 step_total;
   logic                        active_c, better, trial_set;
   logic                        gain_wr, minus_two, step_wr, grow;
   logic signed [GainEff-1:0]   gain_sel, gain_new;
   logic [StepW-1:0]            step_sel, step_new;
   logic signed [34:0]          gain_wide;
   logic [47:0]                 step_prod;
   logic [47:0]                 step_round;
   logic [31:0]                 step_shift;
   logic signed [GainEff+15:0]  pp_c;
   logic signed [GainEff+16:0]  pd_c;
   logic signed [GainEff+31:0]  pi_c;
   logic signed [AccW-1:0]      acc_c, acc_shift;
   logic signed [31:0]          drive_c;

   assign e_c        = $signed(req_tdata[15:0]);
   assign sum_wide   = 33'(sum_ff) + 33'(e_c);
   assign step_total = 33'(step_p_ff) + 33'(step_i_ff) + 33'(step_d_ff);
   assign active_c   = tune_en_ff && (step_total > 33'(step_tol_ff));
   assign better     = mag32(trial_ff) < mag32(best_ff);

   // Operand selection for the gain being tuned.
   always_comb begin
      case (coord_ff)
         pidtw_pkg::CO_P: begin
            gain_sel = gain_p_ff;
            step_sel = step_p_ff;
         end
         pidtw_pkg::CO_D: begin
            gain_sel = gain_d_ff;
            step_sel = step_d_ff;
         end
         default: begin
            gain_sel = gain_i_ff;
            step_sel = step_i_ff;
         end
      endcase
   end

   // Twiddle decision for this sample.
   always_comb begin
      gain_wr   = 1'b0;
      minus_two = 1'b0;
      step_wr   = 1'b0;
      grow      = 1'b1;
      trial_set = 1'b0;
      best_in   = best_ff;
      phase_in  = phase_ff;
      coord_in  = coord_ff;
      if (active_c) begin
         case (phase_ff)
            pidtw_pkg::PH_TRY_UP: begin
               gain_wr   = 1'b1;
               trial_set = 1'b1;
               phase_in  = pidtw_pkg::PH_TRY_DOWN;
            end
            pidtw_pkg::PH_TRY_DOWN: begin
               if (better) begin
                  best_in  = trial_ff;
                  step_wr  = 1'b1;
                  phase_in = pidtw_pkg::PH_NEXT;
               end else begin
                  gain_wr   = 1'b1;
                  minus_two = 1'b1;
                  trial_set = 1'b1;
                  phase_in  = pidtw_pkg::PH_SETTLE;
               end
            end
            pidtw_pkg::PH_SETTLE: begin
               step_wr = 1'b1;
               if (better) begin
                  best_in = trial_ff;
               end else begin
                  gain_wr = 1'b1;
                  grow    = 1'b0;
               end
               phase_in = pidtw_pkg::PH_NEXT;
            end
            default: begin
               phase_in = pidtw_pkg::PH_TRY_UP;
               case (coord_ff)
                  pidtw_pkg::CO_P: coord_in = pidtw_pkg::CO_D;
                  pidtw_pkg::CO_D: coord_in = pidtw_pkg::CO_I;
                  default:         coord_in = pidtw_pkg::CO_P;
               endcase
            end
         endcase
      end
   end

   // Gain step with saturation, and step scaling by 1.1 or 0.9 with rounding.
   assign gain_wide  = 35'(gain_sel) + (minus_two ? -$signed({3'b000, step_sel, 1'b0})
                                                  :  $signed({4'b0000, step_sel}));
   assign gain_new   = sat_gain(gain_wide);
   assign step_prod  = step_sel * (grow ? pidtw_pkg::GROW_K : pidtw_pkg::SHRINK_K);
   assign step_round = step_prod + 48'd32768;
   assign step_shift = step_round[47:16];
   assign step_new   = (step_shift > 32'(pidtw_pkg::STEP_MAX)) ? pidtw_pkg::STEP_MAX
                                                              : step_shift[StepW-1:0];

   // Next state for the sample history and tuning registers; a configuration gain write wins over a tuning update.
   always_comb begin
      last_in   = last_ff;
      delta_in  = delta_ff;
      sum_in    = sum_ff;
      gain_p_in = gain_p_ff;
      gain_i_in = gain_i_ff;
      gain_d_in = gain_d_ff;
      step_p_in = step_p_ff;
      step_i_in = step_i_ff;
      step_d_in = step_d_ff;
      if (take) begin
         last_in  = e_c;
         delta_in = 17'(e_c) - 17'(last_ff);
         if (sum_wide[32] != sum_wide[31]) begin
            sum_in = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         end else begin
            sum_in = sum_wide[31:0];
         end
         case (coord_ff)
            pidtw_pkg::CO_P: begin
               if (gain_wr) gain_p_in = gain_new;
               if (step_wr) step_p_in = step_new;
            end
            pidtw_pkg::CO_D: begin
               if (gain_wr) gain_d_in = gain_new;
               if (step_wr) step_d_in = step_new;
            end
            default: begin
               if (gain_wr) gain_i_in = gain_new;
               if (step_wr) step_i_in = step_new;
            end
         endcase
      end
      if (cfg_wr) begin
         case (cfg_idx)
            pidtw_pkg::REG_GAIN_P: gain_p_in = sat_gain(35'($signed(csr_pwdata)));
            pidtw_pkg::REG_GAIN_I: gain_i_in = sat_gain(35'($signed(csr_pwdata)));
            pidtw_pkg::REG_GAIN_D: gain_d_in = sat_gain(35'($signed(csr_pwdata)));
            default: ;
         endcase
      end
   end

   // Drive from the updated gains and error terms: negated, floored by 8 bits, saturated.
   assign pp_c      = gain_p_in * last_in;
   assign pd_c      = gain_d_in * delta_in;
   assign pi_c      = gain_i_in * sum_in;
   assign acc_c     = -(AccW'(pp_c) + AccW'(pd_c) + AccW'(pi_c));
   assign acc_shift = acc_c >>> 8;

   always_comb begin
      if (acc_shift > DriveMax) begin
         drive_c = 32'sh7FFF_FFFF;
      end else if (acc_shift < DriveMin) begin
         drive_c = 32'sh8000_0000;
      end else begin
         drive_c = acc_shift[31:0];
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_init_ff <= '0;
         gain_i_init_ff <= '0;
         gain_d_init_ff <= '0;
         tune_en_ff     <= 1'b1;
         step_tol_ff    <= pidtw_pkg::TOL_RESET;
      end else if (cfg_wr) begin
         case (cfg_idx)
            pidtw_pkg::REG_GAIN_P:   gain_p_init_ff <= csr_pwdata;
            pidtw_pkg::REG_GAIN_I:   gain_i_init_ff <= csr_pwdata;
            pidtw_pkg::REG_GAIN_D:   gain_d_init_ff <= csr_pwdata;
            pidtw_pkg::REG_TUNE_EN:  tune_en_ff     <= csr_pwdata[0];
            pidtw_pkg::REG_STEP_TOL: step_tol_ff    <= csr_pwdata[StepW-1:0];
            default: ;
         endcase
      end
   end

   // Controller and tuning state.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff   <= '0;
         delta_ff  <= '0;
         sum_ff    <= '0;
         gain_p_ff <= '0;
         gain_i_ff <= '0;
         gain_d_ff <= '0;
         step_p_ff <= pidtw_pkg::STEP_ONE;
         step_i_ff <= pidtw_pkg::STEP_ONE;
         step_d_ff <= pidtw_pkg::STEP_ONE;
         trial_ff  <= '0;
         best_ff   <= pidtw_pkg::BEST_RESET;
         coord_ff  <= pidtw_pkg::CO_P;
         phase_ff  <= pidtw_pkg::PH_TRY_UP;
      end else begin
         last_ff   <= last_in;
         delta_ff  <= delta_in;
         sum_ff    <= sum_in;
         gain_p_ff <= gain_p_in;
         gain_i_ff <= gain_i_in;
         gain_d_ff <= gain_d_in;
         step_p_ff <= step_p_in;
         step_i_ff <= step_i_in;
         step_d_ff <= step_d_in;
         if (take) begin
            best_ff  <= best_in;
            coord_ff <= coord_in;
            phase_ff <= phase_in;
            // The trial score is the drive of the sample that set it.
            if (trial_set) begin
               trial_ff <= drive_c;
            end
         end
      end
   end

   // Result valid: set by a taken sample, cleared when the beat leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload, loaded with each taken sample.
   always_ff @(posedge clock) begin
      if (take) begin
         out_data_ff <= {best_in, 32'(gain_d_in), 32'(gain_i_in), 32'(gain_p_in), drive_c};
         out_user_ff <= active_c;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   // ---------------------------------------------------------------- assertions
   // Step sizes never shrink to zero.
   a_step_nonzero: assert property (@(posedge clock) disable iff (reset)
      (step_p_ff != '0) && (step_i_ff != '0) && (step_d_ff != '0))
      else $error("twiddle step size reached zero");

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("result beat changed while stalled");

   // A tuned sample in the first phase moves to the downward trial.
   a_phase_up: assert property (@(posedge clock) disable iff (reset)
      (take && active_c && phase_ff == pidtw_pkg::PH_TRY_UP)
      |=> (phase_ff == pidtw_pkg::PH_TRY_DOWN))
      else $error("twiddle phase did not advance after upward trial");

   // A taken sample always produces a result beat.
   a_take_result: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_tvalid)
      else $error("taken sample produced no result beat");

endmodule
